FILE: design/limit_order_book_matcher_assert.svh
// Assertion macros used by the checker file of the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LOBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: design/lobm_pkg.sv
// Package with the item types and constants of the order book matcher.
package lobm_pkg;
    localparam int BookDepth = 64;
    localparam int IdxW = $clog2(BookDepth);
    localparam int CntW = $clog2(BookDepth + 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(BookDepth);

    localparam logic [1:0] StatusOk = 2'd0;
    localparam logic [1:0] StatusZero = 2'd1;
    localparam logic [1:0] StatusFull = 2'd2;

    localparam logic ActInsert = 1'b0;
    localparam logic ActMatch = 1'b1;

    typedef logic [IdxW-1:0] t_idx;
    typedef logic [CntW-1:0] t_cnt;

    typedef struct packed {
        logic               action;
        logic [23:0]        limit_price;
        logic signed [23:0] signed_volume;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [23:0]        average_price;
        logic [23:0]        filled_volume;
        logic signed [23:0] remaining_volume;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [24:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [23:0] quotient;
    } t_div_rsp;
endpackage

FILE: design/lobm_ram.sv
// Generic single-port RAM with registered read.
module lobm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/lobm_div.sv
// Restoring divider, one quotient bit per cycle.
module lobm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lobm_pkg::t_div_req i_req,
    output lobm_pkg::t_div_rsp o_rsp
);
    logic [47:0] r_quo;
    logic [48:0] r_rem;
    logic [24:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [48:0] n_rem_sh;
    logic [49:0] n_diff;

    assign n_rem_sh = {r_rem[47:0], r_quo[47]};
    assign n_diff = {1'b0, n_rem_sh} - {25'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 6'd1);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo <= i_req.dividend;
                r_rem <= '0;
                r_den <= i_req.divisor;
                r_cnt <= 6'd48;
            end else if (r_busy) begin
                if (n_diff[49]) begin
                    r_rem <= n_rem_sh;
                    r_quo <= {r_quo[46:0], 1'b0};
                end else begin
                    r_rem <= n_diff[48:0];
                    r_quo <= {r_quo[46:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                r_busy <= (r_cnt != 6'd1);
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo[23:0];
endmodule

FILE: design/limit_order_book_matcher.sv
// Top level of the limit order book matcher.
// Input items arrive on i_in_valid / o_in_stall with payload i_in_item.
// Results leave on o_out_valid / i_out_stall with payload o_out_item.
// Every input item gives exactly one result item.
// The block takes one item at a time and stalls its input while it works.
// An insert, or a match of zero volume, shows its result on the cycle after it
// is accepted. A match scans the opposite side through the shared compare unit,
// applies each fill in S_FILL and then scans again. Unless the taker is filled,
// a last pass finds no crossing order. When anything filled, the divider gives
// the average price.
// Each side keeps one occupancy bit per slot in flip-flops, while prices,
// quantities and stamps sit in RAM.
// Reset clears the sequencer, the occupancy bits, the arrival counter and the output valid flag.
// When the receiver stalls, the result holds on the output register and
// the block accepts nothing new until it is taken.
module limit_order_book_matcher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lobm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lobm_pkg::t_out_item o_out_item
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FILL, S_DIV, S_WAITDIV, S_OUT
    } t_state;

    t_state r_state;
    logic [lobm_pkg::BookDepth-1:0] r_bv;
    logic [lobm_pkg::BookDepth-1:0] r_av;
    logic [31:0] r_arrival;
    logic [23:0] r_limit;
    logic        r_neg;
    logic [23:0] r_left;
    logic [23:0] r_total;
    logic [47:0] r_sum;
    lobm_pkg::t_cnt r_cnt;
    lobm_pkg::t_idx r_addr_q;
    logic        r_rdv;
    logic        r_found;
    lobm_pkg::t_idx r_best;
    logic [23:0] r_bprice;
    logic [31:0] r_bage;
    logic [23:0] r_bqty;
    logic [23:0] r_trade;
    logic        r_out_valid;
    lobm_pkg::t_out_item r_out;
    lobm_pkg::t_div_req  r_dreq;
    lobm_pkg::t_div_rsp  w_drsp;

    lobm_pkg::t_idx w_addr;
    logic          w_ins;
    logic          w_fill;
    logic          w_we_b;
    logic          w_we_a;
    logic          w_we_bq;
    logic          w_we_aq;
    logic [23:0]   w_qwdata;
    logic [23:0]   w_bp_rd;
    logic [23:0]   w_ap_rd;
    logic [31:0]   w_bs_rd;
    logic [31:0]   w_as_rd;
    logic [23:0]   w_bq_rd;
    logic [23:0]   w_aq_rd;
    logic [23:0]   w_mag;
    logic          w_vneg;
    logic [lobm_pkg::BookDepth-1:0] w_side_v;
    logic [1:0]    w_status;
    logic [23:0]   w_pr;
    logic [31:0]   w_age;
    logic [23:0]   w_qrd;
    logic          w_occ;
    logic          w_better;
    logic [47:0]   w_prod;
    lobm_pkg::t_idx w_free;
    logic          w_has_free;
    logic          n_rdv;
    logic          n_dstart;

    assign w_vneg = i_in_item.signed_volume[23];
    assign w_mag = w_vneg ? (24'd0 - i_in_item.signed_volume) : i_in_item.signed_volume;
    assign w_side_v = w_vneg ? r_av : r_bv;
    assign w_ins = (r_state == S_IDLE) && i_in_valid
                   && (i_in_item.action == lobm_pkg::ActInsert)
                   && (w_mag != 24'd0) && w_has_free;
    assign w_we_b = w_ins && !w_vneg;
    assign w_we_a = w_ins && w_vneg;
    assign w_fill = (r_state == S_FILL);
    assign w_we_bq = w_we_b || (w_fill && r_neg);
    assign w_we_aq = w_we_a || (w_fill && !r_neg);
    assign w_qwdata = w_fill ? (r_bqty - r_trade) : w_mag;
    assign w_addr = (r_state == S_SCAN) ? r_cnt[lobm_pkg::IdxW-1:0]
                                        : (w_fill ? r_best : w_free);
    assign w_status = (i_in_item.action != lobm_pkg::ActInsert) ? lobm_pkg::StatusOk
                    : (w_mag == 24'd0) ? lobm_pkg::StatusZero
                    : (!w_has_free) ? lobm_pkg::StatusFull
                    : lobm_pkg::StatusOk;
    assign n_rdv = (r_state == S_SCAN) && (r_cnt != lobm_pkg::DepthCnt);
    assign n_dstart = (r_state == S_DIV) && (r_total != 24'd0);

    always_comb begin
        w_free = '0;
        w_has_free = 1'b0;
        for (int i = lobm_pkg::BookDepth - 1; i >= 0; i--) begin
            if (!w_side_v[i]) begin
                w_free = lobm_pkg::t_idx'(i);
                w_has_free = 1'b1;
            end
        end
    end

    lobm_ram #(.Width(24), .Depth(lobm_pkg::BookDepth)) u_bp (
        .i_clk(i_clk), .i_we(w_we_b), .i_addr(w_addr),
        .i_wdata(i_in_item.limit_price), .o_rdata(w_bp_rd));
    lobm_ram #(.Width(32), .Depth(lobm_pkg::BookDepth)) u_bs (
        .i_clk(i_clk), .i_we(w_we_b), .i_addr(w_addr),
        .i_wdata(r_arrival), .o_rdata(w_bs_rd));
    lobm_ram #(.Width(24), .Depth(lobm_pkg::BookDepth)) u_bq (
        .i_clk(i_clk), .i_we(w_we_bq), .i_addr(w_addr),
        .i_wdata(w_qwdata), .o_rdata(w_bq_rd));
    lobm_ram #(.Width(24), .Depth(lobm_pkg::BookDepth)) u_ap (
        .i_clk(i_clk), .i_we(w_we_a), .i_addr(w_addr),
        .i_wdata(i_in_item.limit_price), .o_rdata(w_ap_rd));
    lobm_ram #(.Width(32), .Depth(lobm_pkg::BookDepth)) u_as (
        .i_clk(i_clk), .i_we(w_we_a), .i_addr(w_addr),
        .i_wdata(r_arrival), .o_rdata(w_as_rd));
    lobm_ram #(.Width(24), .Depth(lobm_pkg::BookDepth)) u_aq (
        .i_clk(i_clk), .i_we(w_we_aq), .i_addr(w_addr),
        .i_wdata(w_qwdata), .o_rdata(w_aq_rd));

    lobm_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_dreq), .o_rsp(w_drsp));

    assign w_pr = r_neg ? w_bp_rd : w_ap_rd;
    assign w_age = r_arrival - (r_neg ? w_bs_rd : w_as_rd);
    assign w_qrd = r_neg ? w_bq_rd : w_aq_rd;
    assign w_occ = r_neg ? r_bv[r_addr_q] : r_av[r_addr_q];
    always_comb begin
        if (!r_found) begin
            w_better = 1'b1;
        end else if (w_pr != r_bprice) begin
            w_better = r_neg ? (w_pr > r_bprice) : (w_pr < r_bprice);
        end else begin
            w_better = w_age > r_bage;
        end
    end
    assign w_prod = r_bprice * r_trade;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_arrival <= '0;
            r_out_valid <= 1'b0;
            r_dreq.start <= 1'b0;
            r_rdv <= 1'b0;
            r_bv <= '0;
            r_av <= '0;
        end else begin
            r_dreq.start <= n_dstart;
            r_rdv <= n_rdv;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_limit <= i_in_item.limit_price;
                        r_neg <= w_vneg;
                        r_left <= w_mag;
                        r_total <= '0;
                        r_sum <= '0;
                        r_out.status <= w_status;
                        r_out.average_price <= '0;
                        r_out.filled_volume <= '0;
                        r_out.remaining_volume <= '0;
                        if (i_in_item.action == lobm_pkg::ActInsert) begin
                            if (w_ins) begin
                                r_arrival <= r_arrival + 32'd1;
                                if (w_vneg) begin
                                    r_av[w_free] <= 1'b1;
                                end else begin
                                    r_bv[w_free] <= 1'b1;
                                end
                            end
                            r_out_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else if (w_mag == 24'd0) begin
                            r_out_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_cnt <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (n_rdv) begin
                        r_cnt <= r_cnt + lobm_pkg::t_cnt'(1);
                        r_addr_q <= r_cnt[lobm_pkg::IdxW-1:0];
                    end
                    if (r_rdv && w_occ && w_better) begin
                        r_found <= 1'b1;
                        r_best <= r_addr_q;
                        r_bprice <= w_pr;
                        r_bage <= w_age;
                        r_bqty <= w_qrd;
                    end
                    if (!r_rdv && r_cnt == lobm_pkg::DepthCnt) begin
                        if (!r_found || (r_neg ? (r_limit > r_bprice)
                                               : (r_limit < r_bprice))) begin
                            r_state <= S_DIV;
                        end else begin
                            r_trade <= (r_bqty < r_left) ? r_bqty : r_left;
                            r_state <= S_FILL;
                        end
                    end
                end
                S_FILL: begin
                    if (r_bqty == r_trade) begin
                        if (r_neg) begin
                            r_bv[r_best] <= 1'b0;
                        end else begin
                            r_av[r_best] <= 1'b0;
                        end
                    end
                    r_left <= r_left - r_trade;
                    r_total <= r_total + r_trade;
                    r_sum <= r_sum + w_prod;
                    r_cnt <= '0;
                    r_found <= 1'b0;
                    r_state <= (r_left == r_trade) ? S_DIV : S_SCAN;
                end
                S_DIV: begin
                    r_out.filled_volume <= r_total;
                    r_out.remaining_volume <= r_neg ? (24'd0 - r_left) : r_left;
                    r_dreq.dividend <= r_sum;
                    r_dreq.divisor <= {1'b0, r_total};
                    if (r_total == 24'd0) begin
                        r_out_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_WAITDIV;
                    end
                end
                S_WAITDIV: begin
                    if (w_drsp.done) begin
                        r_out.average_price <= w_drsp.quotient;
                        r_out_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;
endmodule

FILE: design/lobm_checker.sv
// Port-level checker for the order book matcher, bound to the top level.
`include "limit_order_book_matcher_assert.svh"
module lobm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input lobm_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lobm_pkg::t_out_item o_out_item
);
    `LOBM_ASSERT_IMPL(a_busy_while_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `LOBM_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `LOBM_ASSERT_IMPL(a_status_range, i_clk, i_rst_n, o_out_valid, o_out_item.status != 2'd3)
    `LOBM_ASSERT_NEXT(a_accept_stalls, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);

FILE: sim/tb_limit_order_book_matcher.sv
// Self-checking testbench of the limit order book matcher: directed table, a full bid side, then random traffic.
`timescale 1ns / 1ps
module tb_limit_order_book_matcher;
    import lobm_pkg::*;

    localparam int NumRandom = 1168;
    localparam int Depth = BookDepth;

    typedef struct {
        t_in_item  item;
        logic      known;
        t_out_item result;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;

    logic [23:0] bid_px [Depth];
    logic [24:0] bid_qty [Depth];
    logic [31:0] bid_ts [Depth];
    logic [23:0] ask_px [Depth];
    logic [24:0] ask_qty [Depth];
    logic [31:0] ask_ts [Depth];
    logic [31:0] arrivals;

    t_out_item  pending_results[$];
    t_row       rows[$];
    int         errors = 0;
    int         results_seen = 0;
    int         fills_seen = 0;
    int         full_seen = 0;
    bit         hold_off = 1'b0;
    bit         random_stall = 1'b1;

    limit_order_book_matcher DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int find_best(input bit bids);
        int best;
        logic [23:0] bp;
        logic [31:0] ba;
        logic [31:0] age;
        logic [23:0] p;
        best = -1;
        bp = '0;
        ba = '0;
        for (int i = 0; i < Depth; i++) begin
            if ((bids ? bid_qty[i] : ask_qty[i]) != 0) begin
                p = bids ? bid_px[i] : ask_px[i];
                age = arrivals - (bids ? bid_ts[i] : ask_ts[i]);
                if (best < 0 || (p != bp && (bids ? p > bp : p < bp)) ||
                        (p == bp && age > ba)) begin
                    best = i;
                    bp = p;
                    ba = age;
                end
            end
        end
        return best;
    endfunction

    function automatic t_out_item book_step(input t_in_item it);
        t_out_item r;
        logic neg;
        logic [24:0] mag;
        logic [24:0] left;
        logic [24:0] total;
        logic [24:0] trade;
        logic [63:0] notional;
        logic [23:0] p;
        int b;
        int slot;
        r = '0;
        neg = it.signed_volume[23];
        mag = neg ? 25'h1000000 - {1'b0, it.signed_volume} : {1'b0, it.signed_volume};
        if (it.action == ActInsert) begin
            if (mag == 0) begin
                r.status = StatusZero;
            end else begin
                slot = -1;
                for (int i = Depth - 1; i >= 0; i--) begin
                    if ((neg ? ask_qty[i] : bid_qty[i]) == 0) slot = i;
                end
                if (slot < 0) begin
                    r.status = StatusFull;
                end else if (neg) begin
                    ask_px[slot] = it.limit_price;
                    ask_qty[slot] = mag;
                    ask_ts[slot] = arrivals;
                    arrivals++;
                end else begin
                    bid_px[slot] = it.limit_price;
                    bid_qty[slot] = mag;
                    bid_ts[slot] = arrivals;
                    arrivals++;
                end
            end
        end else if (mag != 0) begin
            left = mag;
            total = '0;
            notional = '0;
            while (left != 0) begin
                b = find_best(neg);
                if (b < 0) break;
                p = neg ? bid_px[b] : ask_px[b];
                if (neg ? it.limit_price > p : it.limit_price < p) break;
                trade = neg ? bid_qty[b] : ask_qty[b];
                if (trade > left) trade = left;
                if (neg) bid_qty[b] -= trade;
                else ask_qty[b] -= trade;
                left -= trade;
                total += trade;
                notional += 64'(p) * 64'(trade);
            end
            if (total != 0) r.average_price = 24'(notional / 64'(total));
            r.filled_volume = total[23:0];
            r.remaining_volume = neg ? 24'(25'h1000000 - left) : left[23:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
    endtask

    task automatic add_row(input logic act, input logic [23:0] px, input logic [23:0] vol,
                           input logic known, input t_out_item res);
        t_row r;
        r.item.action = act;
        r.item.limit_price = px;
        r.item.signed_volume = vol;
        r.known = known;
        r.result = res;
        rows.push_back(r);
    endtask

    task automatic send_item(input t_in_item it, input t_out_item typed, input logic known);
        t_out_item want;
        want = book_step(it);
        if (known && want != typed) begin
            report_mismatch("table", want[23:0], typed[23:0]);
        end
        pending_results.push_back(want);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (want.filled_volume != 0) fills_seen++;
        if (want.status == StatusFull) full_seen++;
    endtask

    task automatic random_gap();
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        logic [23:0] mag;
        it.action = $urandom_range(0, 9) < 5 ? ActInsert : ActMatch;
        case ($urandom_range(0, 9))
            0: it.limit_price = 24'($urandom());
            1: it.limit_price = $urandom_range(0, 1) ? 24'hffffff : 24'h0;
            default: it.limit_price = 24'(24'h010000 + $urandom_range(0, 63));
        endcase
        case ($urandom_range(0, 19))
            0: mag = 24'h0;
            1: mag = 24'($urandom());
            2: mag = 24'h7fffff;
            default: mag = 24'($urandom_range(1, 300));
        endcase
        it.signed_volume = $urandom_range(0, 1) ? -$signed(mag) : mag;
        if ($urandom_range(0, 40) == 0) it.signed_volume = 24'h800000;
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else if (random_stall) i_out_stall <= ($urandom_range(0, 3) == 0);
        else i_out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("Unexpected result %0d", results_seen);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status != want.status)
                    report_mismatch("status", 24'(o_out_item.status), 24'(want.status));
                if (o_out_item.average_price != want.average_price)
                    report_mismatch("average", o_out_item.average_price, want.average_price);
                if (o_out_item.filled_volume != want.filled_volume)
                    report_mismatch("filled", o_out_item.filled_volume, want.filled_volume);
                if (o_out_item.remaining_volume != want.remaining_volume)
                    report_mismatch("remaining", o_out_item.remaining_volume,
                                    want.remaining_volume);
            end
        end
    end

    initial begin
        t_out_item ok;
        t_out_item zero_rej;
        t_out_item none;
        t_in_item it;
        int burst;
        int wait_cycles;
        for (int i = 0; i < Depth; i++) begin
            bid_qty[i] = '0;
            ask_qty[i] = '0;
        end
        arrivals = '0;
        ok = '0;
        zero_rej = '0;
        zero_rej.status = StatusZero;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(ActMatch, 24'h000100, 24'h000010, 1'b1, '{StatusOk, 24'h0, 24'h0, 24'h10});
        add_row(ActMatch, 24'hffffff, 24'hfffff0, 1'b1, '{StatusOk, 24'h0, 24'h0, 24'hfffff0});
        add_row(ActInsert, 24'h000100, 24'h000000, 1'b1, zero_rej);
        add_row(ActMatch, 24'h000100, 24'h000000, 1'b1, ok);
        add_row(ActInsert, 24'h000000, 24'h7fffff, 1'b1, ok);
        add_row(ActInsert, 24'hffffff, 24'h800000, 1'b1, ok);
        add_row(ActInsert, 24'h000200, 24'h000005, 1'b1, ok);
        add_row(ActInsert, 24'h000200, 24'h000003, 1'b1, ok);
        add_row(ActInsert, 24'h000300, 24'hfffffc, 1'b1, ok);
        add_row(ActInsert, 24'h000301, 24'hfffffe, 1'b1, ok);
        add_row(ActMatch, 24'h000100, 24'hfffff9, 1'b0, none);
        add_row(ActMatch, 24'h000400, 24'h000005, 1'b0, none);
        add_row(ActMatch, 24'h0002ff, 24'h000002, 1'b0, none);
        add_row(ActMatch, 24'h000000, 24'h800000, 1'b0, none);
        add_row(ActMatch, 24'hffffff, 24'h7fffff, 1'b0, none);
        foreach (rows[i]) begin
            send_item(rows[i].item, rows[i].result, rows[i].known);
            random_gap();
        end

        // Fill the bid side past its depth while the receiver holds off.
        hold_off = 1'b1;
        fork
            begin
                wait_cycles = 0;
                while (wait_cycles < 400) begin
                    @(posedge i_clk);
                    wait_cycles++;
                end
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < Depth + 2; i++) begin
                    it.action = ActInsert;
                    it.limit_price = 24'(24'h010000 + i);
                    it.signed_volume = 24'(1 + i);
                    send_item(it, none, 1'b0);
                end
            end
        join
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        it.action = ActMatch;
        it.limit_price = 24'h0;
        it.signed_volume = 24'h800000;
        send_item(it, none, 1'b0);

        for (int n = 0; n < NumRandom; ) begin
            random_stall = (n % 400) < 300;
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++) begin
                send_item(random_item(), none, 1'b0);
                n++;
            end
            i_in_valid <= 1'b0;
            if (n % 500 < burst) begin
                while (pending_results.size() != 0) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4000) @(posedge i_clk);
        $display("Covered %0d results, %0d with fills, %0d full-side rejects.",
                 results_seen, fills_seen, full_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
